FILE: rtl/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared types, codes and reset values for the button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpdc_pkg;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int LIMIT_BITS       = 16;
	localparam int CODE_BITS        = 4;
	localparam int NUM_LANES        = 3;

	// Key codes: base code of each button, plus grade minus one.
	localparam logic [CODE_BITS-1:0] CODE_NONE = 4'd0;
	localparam logic [CODE_BITS-1:0] CODE_SET  = 4'd1;
	localparam logic [CODE_BITS-1:0] CODE_UP   = 4'd4;
	localparam logic [CODE_BITS-1:0] CODE_DOWN = 4'd7;

	// Press grades reported by a lane on release.
	localparam logic [1:0] GRADE_NONE      = 2'd0;
	localparam logic [1:0] GRADE_SHORT     = 2'd1;
	localparam logic [1:0] GRADE_LONG      = 2'd2;
	localparam logic [1:0] GRADE_VERY_LONG = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MIRROR    = 2'd0;
	localparam logic [1:0] REG_SHORT     = 2'd1;
	localparam logic [1:0] REG_LONG      = 2'd2;
	localparam logic [1:0] REG_VERY_LONG = 2'd3;

	localparam logic [LIMIT_BITS-1:0] SHORT_RST     = 16'd10;
	localparam logic [LIMIT_BITS-1:0] LONG_RST      = 16'd1000;
	localparam logic [LIMIT_BITS-1:0] VERY_LONG_RST = 16'd2200;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] short_lim;
		logic [LIMIT_BITS-1:0] long_lim;
		logic [LIMIT_BITS-1:0] very_long_lim;
	} limits_t;

	// Per-tick control shared by all lanes.
	typedef struct packed {
		logic tick;   // accepted tick while no code is latched
		logic flush;  // accepted tick while a code is latched
	} lane_ctrl_t;

	typedef logic [NUM_LANES-1:0][1:0] grades_t;

endpackage

`default_nettype wire

FILE: rtl/bpdc_lane.sv
// ----------------------------------------------------------------------------
// bpdc_lane
// One button: saturating hold counter and release grading.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_lane #(
	parameter int COUNTER_BITS = bpdc_pkg::COUNTER_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bpdc_pkg::lane_ctrl_t ctrl,
	input  wire                  pressed,
	input  bpdc_pkg::limits_t    limits,
	output logic [1:0]           grade
);
	import bpdc_pkg::*;

	localparam int W = (COUNTER_BITS > LIMIT_BITS) ? COUNTER_BITS : LIMIT_BITS;

	logic [COUNTER_BITS-1:0] count_q;
	logic [W-1:0]            held;

	assign held = W'(count_q);

	// Grade is only meaningful on a release; a held button reports none.
	always_comb begin
		grade = GRADE_NONE;
		if (!pressed) begin
			if (held > W'(limits.very_long_lim)) begin
				grade = GRADE_VERY_LONG;
			end else if (held > W'(limits.long_lim)) begin
				grade = GRADE_LONG;
			end else if (held > W'(limits.short_lim)) begin
				grade = GRADE_SHORT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.flush || (ctrl.tick && !pressed)) begin
			count_q <= '0;
		end else if (ctrl.tick && (count_q != '1)) begin
			count_q <= count_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bpdc_merge.sv
// ----------------------------------------------------------------------------
// bpdc_merge
// Combines lane grades into a latched key code and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_merge (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                tick,
	input  wire                                read,
	input  wire                                mirror,
	input  bpdc_pkg::grades_t                  grades,
	input  wire                                out_ready,
	output logic                               out_valid,
	output logic [bpdc_pkg::CODE_BITS-1:0]     key_code,
	output logic                               code_held
);
	import bpdc_pkg::*;

	logic [CODE_BITS-1:0] latched_q;
	logic [CODE_BITS-1:0] key_code_q;
	logic                 out_valid_q;
	logic [CODE_BITS-1:0] base [NUM_LANES];
	logic [CODE_BITS-1:0] new_code;
	logic                 new_hit;

	always_comb begin
		base[0] = mirror ? CODE_DOWN : CODE_SET;
		base[1] = CODE_UP;
		base[2] = mirror ? CODE_SET : CODE_DOWN;
	end

	// Later lanes win, matching the button handling order.
	always_comb begin
		new_code = CODE_NONE;
		new_hit  = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (grades[i] != GRADE_NONE) begin
				new_code = base[i] + CODE_BITS'(grades[i]) - 1'b1;
				new_hit  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= CODE_NONE;
		end else if (read) begin
			latched_q <= CODE_NONE;
		end else if (tick && new_hit) begin
			latched_q <= new_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read) begin
			key_code_q <= latched_q;
		end
	end

	assign out_valid = out_valid_q;
	assign key_code  = key_code_q;
	assign code_held = (latched_q != CODE_NONE);

endmodule

`default_nettype wire

FILE: rtl/button_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// button_press_duration_classifier
// Grades presses of three buttons by hold time and reports a key code on read.
// ----------------------------------------------------------------------------
//
//   Channel  | Signals                                          | Direction
//   ---------+--------------------------------------------------+----------
//   input    | in_valid, in_ready, action, first/second/third_  | in
//   result   | out_valid, out_ready, key_code                   | out
//   config   | psel, penable, pwrite, paddr, pwdata, prdata,    | in/out
//            | pready                                           |
//
// A new input transfer can be taken every cycle while the result sink is
// not stalling. A read transfer yields its key code on the result port in
// the following cycle, from a single output register. Input ready drops
// only while that register holds a result that the sink is not taking, so
// a stalled sink stalls the input as soon as that register is full. Reset
// clears all hold counters, the latched code and the configuration to its
// defaults; there is no clearing pass.
//
// Three identical lanes, one per button, each keep a saturating hold
// counter and grade the hold time on release. The merge stage picks the
// last lane that graded a press, maps it to a key code (with the set and
// down roles swapped in mirror mode) and latches it. While a code is
// latched, every tick clears all counters instead of counting.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_duration_classifier #(
	parameter int COUNTER_BITS = bpdc_pkg::COUNTER_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// input channel
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire                             action,
	input  wire                             first_pressed,
	input  wire                             second_pressed,
	input  wire                             third_pressed,
	// result channel
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [bpdc_pkg::CODE_BITS-1:0]  key_code,
	// configuration port
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire  [3:0]                      paddr,
	input  wire  [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import bpdc_pkg::*;

	logic                 mirror_q;
	limits_t              limits_q;
	logic                 cfg_write;
	logic [1:0]           cfg_idx;
	logic                 in_xfer;
	logic                 read;
	logic                 code_held;
	lane_ctrl_t           ctrl;
	grades_t              grades;
	logic [NUM_LANES-1:0] pressed;

	// ---- configuration registers -------------------------------------------
	assign pready    = 1'b1;
	assign cfg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q                <= 1'b0;
			limits_q.short_lim      <= SHORT_RST;
			limits_q.long_lim       <= LONG_RST;
			limits_q.very_long_lim  <= VERY_LONG_RST;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_MIRROR:    mirror_q               <= pwdata[0];
				REG_SHORT:     limits_q.short_lim     <= pwdata[LIMIT_BITS-1:0];
				REG_LONG:      limits_q.long_lim      <= pwdata[LIMIT_BITS-1:0];
				REG_VERY_LONG: limits_q.very_long_lim <= pwdata[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MIRROR:    prdata = {31'd0, mirror_q};
			REG_SHORT:     prdata = 32'(limits_q.short_lim);
			REG_LONG:      prdata = 32'(limits_q.long_lim);
			REG_VERY_LONG: prdata = 32'(limits_q.very_long_lim);
			default:       prdata = 32'd0;
		endcase
	end

	// ---- input handshake and lane control ----------------------------------
	// Input is blocked only while a result is stalled in the output register.
	assign in_ready = !out_valid || out_ready;
	assign in_xfer  = in_valid && in_ready;
	assign read     = in_xfer && action;

	assign ctrl.tick  = in_xfer && !action && !code_held;
	assign ctrl.flush = in_xfer && !action && code_held;

	assign pressed = {third_pressed, second_pressed, first_pressed};

	// ---- per-button lanes ---------------------------------------------------
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		bpdc_lane #(
			.COUNTER_BITS(COUNTER_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.pressed(pressed[g]),
			.limits (limits_q),
			.grade  (grades[g])
		);
	end

	// ---- merge, latched code and result register ---------------------------
	bpdc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (ctrl.tick),
		.read     (read),
		.mirror   (mirror_q),
		.grades   (grades),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.key_code (key_code),
		.code_held(code_held)
	);

endmodule

`default_nettype wire

FILE: tb/sv/bpdc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_tb_pkg
// Codes and sizes shared by the classifier testbench top and its checker.
// ----------------------------------------------------------------------------
package bpdc_tb_pkg;

	// Meaning of the action field of an input transfer.
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// The bench runs the block with its default hold counter width.
	localparam int HOLD_BITS = bpdc_pkg::COUNTER_BITS_DEF;

endpackage

FILE: tb/sv/bpdc_key_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_key_code_checker
// Watches the input, result and register channels of the classifier, keeps
// its own copy of the hold counters, latched code and limits, and compares
// every key code and register readback with what that copy predicts.
// ----------------------------------------------------------------------------
module bpdc_key_code_checker #(
	parameter int COUNTER_BITS = bpdc_pkg::COUNTER_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	input  wire                            in_ready,
	input  wire                            action,
	input  wire                            first_pressed,
	input  wire                            second_pressed,
	input  wire                            third_pressed,
	input  wire                            out_valid,
	input  wire                            out_ready,
	input  wire [bpdc_pkg::CODE_BITS-1:0]  key_code,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [3:0]                      paddr,
	input  wire [31:0]                     pwdata,
	input  wire [31:0]                     prdata,
	input  wire                            pready,
	output int                             mismatches,
	output int                             pending,
	output int                             results_seen,
	output int                             presses_seen
);
	import bpdc_pkg::*;
	import bpdc_tb_pkg::*;

	localparam logic [COUNTER_BITS-1:0] HOLD_MAX = '1;

	logic                    mirror;
	logic [LIMIT_BITS-1:0]   short_lim;
	logic [LIMIT_BITS-1:0]   long_lim;
	logic [LIMIT_BITS-1:0]   very_long_lim;
	logic [COUNTER_BITS-1:0] hold_ticks [NUM_LANES];
	logic [CODE_BITS-1:0]    latched;
	logic [CODE_BITS-1:0]    want_code;
	logic [NUM_LANES-1:0]    levels;
	logic [1:0]              grade;
	logic [CODE_BITS-1:0]    code_queue [$];

	int fail_count    = 0;
	int pending_count = 0;
	int result_count  = 0;
	int press_count   = 0;

	assign mismatches   = fail_count;
	assign pending      = pending_count;
	assign results_seen = result_count;
	assign presses_seen = press_count;

	function automatic logic [1:0] grade_hold(input logic [COUNTER_BITS-1:0] ticks);
		if (ticks > very_long_lim)
			return GRADE_VERY_LONG;
		if (ticks > long_lim)
			return GRADE_LONG;
		if (ticks > short_lim)
			return GRADE_SHORT;
		return GRADE_NONE;
	endfunction

	// In mirror mode the first and third buttons trade their code ranges.
	function automatic logic [CODE_BITS-1:0] lane_base(input int lane);
		case (lane)
			0: return mirror ? CODE_DOWN : CODE_SET;
			1: return CODE_UP;
			default: return mirror ? CODE_SET : CODE_DOWN;
		endcase
	endfunction

	function automatic logic [31:0] reg_contents(input logic [1:0] idx);
		case (idx)
			REG_MIRROR: return {31'b0, mirror};
			REG_SHORT:  return {16'b0, short_lim};
			REG_LONG:   return {16'b0, long_lim};
			default:    return {16'b0, very_long_lim};
		endcase
	endfunction

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror        = 1'b0;
			short_lim     = SHORT_RST;
			long_lim      = LONG_RST;
			very_long_lim = VERY_LONG_RST;
			for (int lane = 0; lane < NUM_LANES; lane++)
				hold_ticks[lane] = '0;
			latched = CODE_NONE;
			code_queue.delete();
			pending_count = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_MIRROR: mirror        = pwdata[0];
						REG_SHORT:  short_lim     = pwdata[LIMIT_BITS-1:0];
						REG_LONG:   long_lim      = pwdata[LIMIT_BITS-1:0];
						default:    very_long_lim = pwdata[LIMIT_BITS-1:0];
					endcase
				end else if (prdata !== reg_contents(paddr[3:2])) begin
					flag("register readback", reg_contents(paddr[3:2]), prdata);
				end
			end

			if (in_valid && in_ready) begin
				if (action == ACT_READ) begin
					code_queue.push_back(latched);
					latched = CODE_NONE;
				end else if (latched == CODE_NONE) begin
					levels = {third_pressed, second_pressed, first_pressed};
					// Lanes go in order, so a later release overwrites the code.
					for (int lane = 0; lane < NUM_LANES; lane++) begin
						if (levels[lane]) begin
							if (hold_ticks[lane] != HOLD_MAX)
								hold_ticks[lane]++;
						end else begin
							grade = grade_hold(hold_ticks[lane]);
							if (grade != GRADE_NONE)
								latched = lane_base(lane) +
									{{(CODE_BITS-2){1'b0}}, grade} - 1'b1;
							hold_ticks[lane] = '0;
						end
					end
				end else begin
					for (int lane = 0; lane < NUM_LANES; lane++)
						hold_ticks[lane] = '0;
				end
			end

			if (out_valid && out_ready) begin
				if (code_queue.size() == 0) begin
					flag("key code with no read outstanding", 32'(CODE_NONE),
						32'(key_code));
				end else begin
					want_code = code_queue.pop_front();
					result_count++;
					if (want_code != CODE_NONE)
						press_count++;
					if (key_code !== want_code)
						flag("key code", 32'(want_code), 32'(key_code));
				end
			end

			pending_count = code_queue.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the button press classifier with directed and random button
// activity under several limit settings, with random gaps on both channels,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
	import bpdc_pkg::*;
	import bpdc_tb_pkg::*;

	// The limit leaves ample room for the slowest correct run, even with
	// every gap and stall at its longest.
	localparam int CYCLE_LIMIT = 1_000_000;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        action         = ACT_TICK;
	logic        first_pressed  = 1'b0;
	logic        second_pressed = 1'b0;
	logic        third_pressed  = 1'b0;
	logic        out_ready      = 1'b0;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [3:0]  paddr          = 4'd0;
	logic [31:0] pwdata         = 32'd0;

	wire                 in_ready;
	wire                 out_valid;
	wire [CODE_BITS-1:0] key_code;
	wire [31:0]          prdata;
	wire                 pready;

	int mismatches;
	int pending;
	int results_seen;
	int presses_seen;

	int items_sent   = 0;
	int settings_run = 0;
	int cycles       = 0;

	// When set, neither side inserts gaps, so back-to-back transfers occur.
	bit quiet = 1'b0;

	// Limits last written, used only to aim hold lengths near the thresholds.
	logic [15:0] cfg_short = SHORT_RST;
	logic [15:0] cfg_long  = LONG_RST;
	logic [15:0] cfg_very  = VERY_LONG_RST;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	button_press_duration_classifier #(
		.COUNTER_BITS(HOLD_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.first_pressed (first_pressed),
		.second_pressed(second_pressed),
		.third_pressed (third_pressed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.key_code      (key_code),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	bpdc_key_code_checker #(
		.COUNTER_BITS(HOLD_BITS)
	) code_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.first_pressed (first_pressed),
		.second_pressed(second_pressed),
		.third_pressed (third_pressed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.key_code      (key_code),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.pending       (pending),
		.results_seen  (results_seen),
		.presses_seen  (presses_seen)
	);

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: before each transfer the sink holds ready low for a random
	// number of cycles, then keeps it high until a result is taken. With a
	// zero stall ready simply stays high, so it is never dropped and raised in
	// the same step.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// One input transfer. The gap before it is drawn per item; valid only
	// drops when a gap follows, and the payload is held until the transfer
	// completes.
	task automatic send(input logic act, input logic [2:0] lv);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		action         <= act;
		first_pressed  <= lv[0];
		second_pressed <= lv[1];
		third_pressed  <= lv[2];
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic hold_levels(input logic [2:0] lv, input int n);
		repeat (n) send(ACT_TICK, lv);
	endtask

	// Stops input and waits until every read has produced its code. A tick
	// makes no result, so a few more cycles let the last one settle before
	// any register changes. The first edge makes sure the checker has already
	// counted a read taken at the edge where this task is entered.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register transfer: setup cycle, then access until pready. Select is
	// left high so that transfers can follow back to back; apb_release ends a
	// burst.
	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reads every register; the checker compares each value with its copy.
	task automatic read_back_all();
		apb_xfer(1'b0, REG_MIRROR, 32'd0);
		apb_xfer(1'b0, REG_SHORT, 32'd0);
		apb_xfer(1'b0, REG_LONG, 32'd0);
		apb_xfer(1'b0, REG_VERY_LONG, 32'd0);
	endtask

	task automatic set_config(input logic m, input logic [15:0] s, input logic [15:0] l,
		input logic [15:0] v);
		apb_xfer(1'b1, REG_MIRROR, {31'b0, m});
		apb_xfer(1'b1, REG_SHORT, {16'b0, s});
		apb_xfer(1'b1, REG_LONG, {16'b0, l});
		apb_xfer(1'b1, REG_VERY_LONG, {16'b0, v});
		read_back_all();
		apb_release();
		cfg_short = s;
		cfg_long  = l;
		cfg_very  = v;
		settings_run++;
	endtask

	// Hold lengths cluster around the limits, one below, at and one above,
	// since that is where the grading decisions flip.
	function automatic int pick_hold(input int hmax);
		int lim;
		case ($urandom_range(0, 3))
			0: lim = int'(cfg_short);
			1: lim = int'(cfg_long);
			2: lim = int'(cfg_very);
			default: lim = -1;
		endcase
		if (lim < 0 || lim + 1 > hmax)
			return $urandom_range(1, hmax);
		lim = lim + int'($urandom_range(0, 2)) - 1;
		return (lim < 1) ? 1 : lim;
	endfunction

	// A realistic burst of activity: each button is pressed for a chosen
	// length, or not at all, from a staggered start, all are released, and
	// the code is usually read afterwards. Occasional contact bounce, early
	// reads and skipped reads break the pattern.
	task automatic press_gesture(input int hmax);
		int hold_len [3];
		int start [3];
		int span;
		logic [2:0] lv;
		span = 0;
		for (int b = 0; b < 3; b++) begin
			hold_len[b] = ($urandom_range(0, 3) == 0) ? 0 : pick_hold(hmax);
			start[b]    = $urandom_range(0, 3);
			if (start[b] + hold_len[b] > span)
				span = start[b] + hold_len[b];
		end
		for (int t = 0; t <= span; t++) begin
			for (int b = 0; b < 3; b++)
				lv[b] = (t >= start[b]) && (t < start[b] + hold_len[b]);
			if ($urandom_range(0, 29) == 0)
				lv[$urandom_range(0, 2)] ^= 1'b1;
			if ($urandom_range(0, 39) == 0)
				send(ACT_READ, lv);
			send(ACT_TICK, lv);
		end
		if ($urandom_range(0, 7) != 0)
			send(ACT_READ, 3'($urandom_range(0, 7)));
	endtask

	task automatic run_phase(input int n_items, input int hmax);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 4))
					send(($urandom_range(0, 3) == 0) ? ACT_READ : ACT_TICK,
						3'($urandom_range(0, 7)));
			else
				press_gesture(hmax);
		end
		drain();
	endtask

	initial begin
		logic [15:0] s;
		logic [15:0] l;
		logic [15:0] v;
		int top_lim;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of the registers; the writes below continue the burst.
		read_back_all();

		// Directed part with tight limits so that every grade is quick to reach.
		set_config(1'b0, 16'd1, 16'd3, 16'd5);
		// A short press on the set button.
		hold_levels(3'b001, 2);
		hold_levels(3'b000, 1);
		send(ACT_READ, 3'b000);
		// A read with nothing latched returns no code; its button bits are ignored.
		send(ACT_READ, 3'b111);
		// All three released in the same tick: the down button wins.
		hold_levels(3'b111, 6);
		hold_levels(3'b000, 1);
		send(ACT_READ, 3'b101);
		// A press too short to grade still clears its counter.
		hold_levels(3'b010, 1);
		hold_levels(3'b000, 1);
		send(ACT_READ, 3'b000);
		// A long up press, then ticks while it is latched are ignored.
		hold_levels(3'b010, 4);
		hold_levels(3'b000, 1);
		hold_levels(3'b001, 1);
		hold_levels(3'b000, 1);
		send(ACT_READ, 3'b010);
		drain();

		// Random phases over a range of settings, the extremes among them.
		set_config(1'b0, SHORT_RST, LONG_RST, VERY_LONG_RST);
		run_phase(250, 14);
		set_config(1'b0, 16'd2, 16'd6, 16'd12);
		run_phase(250, 16);
		set_config(1'b1, 16'd0, 16'd3, 16'd9);
		run_phase(250, 12);
		// Limits out of order: the first one exceeded, from the top, wins.
		set_config(1'b1, 16'd14, 16'd3, 16'd8);
		run_phase(200, 18);
		// Every hold grades very long.
		set_config(1'b0, 16'd0, 16'd0, 16'd0);
		run_phase(150, 6);
		// No hold can grade at all.
		set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(100, 10);
		repeat (3) begin
			s = 16'($urandom_range(0, 10));
			l = 16'($urandom_range(0, 20));
			v = 16'($urandom_range(0, 30));
			top_lim = (s > l) ? int'(s) : int'(l);
			top_lim = (int'(v) > top_lim) ? int'(v) : top_lim;
			set_config(1'($urandom_range(0, 1)), s, l, v);
			run_phase(180, top_lim + 4);
		end

		$display("Run covered %0d input transfers over %0d register settings,",
			items_sent, settings_run);
		$display("with %0d key code results checked, %0d of them carrying a press.",
			results_seen, presses_seen);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
rtl/bpdc_pkg.sv
rtl/bpdc_lane.sv
rtl/bpdc_merge.sv
rtl/button_press_duration_classifier.sv
tb/sv/bpdc_tb_pkg.sv
tb/sv/bpdc_key_code_checker.sv
tb/sv/tb_top.sv
